/* src/gin_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gin_pkg
// Shared constants, codes and control types of the greedy IoU NMS block.
// ----------------------------------------------------------------------------
package gin_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;
  // register stages of the overlap test unit, each one a slot of the ring
  localparam int PIPE_DEPTH     = 5;

  localparam int ID_W      = 16;
  localparam int SCORE_W   = 16;
  localparam int THR_W     = 17;
  localparam int DET_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DET       = 1'd1;

  localparam logic [THR_W-1:0] THR_RESET = 17'd32768;
  localparam logic [DET_W-1:0] DET_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RING,
    ST_EMIT
  } gin_state_e;

  // control broadcast to the cell chains and the test unit
  typedef struct packed {
    logic rank_ins;
    logic rank_shift;
    logic rank_clear;
    logic id_ins;
    logic id_shift;
  } gin_ctl_t;

endpackage

/* src/gin_rank_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gin_rank_cell
// One cell of the score chain: insertion by score during load, ring shift
// toward the head during suppression.
// ----------------------------------------------------------------------------
module gin_rank_cell #(
  parameter int CB = gin_pkg::COORD_BITS_DEF,
  parameter int IW = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gin_pkg::gin_ctl_t               ctl_i,
  input  logic [32+4*CB+IW-1:0]           new_box_i,
  input  logic [32+4*CB+IW-1:0]           prev_box_i,
  input  logic                            prev_valid_i,
  input  logic                            prev_ins_i,
  input  logic [32+4*CB+IW-1:0]           next_box_i,
  input  logic                            next_valid_i,
  output logic [32+4*CB+IW-1:0]           box_o,
  output logic                            valid_o,
  output logic                            ins_o
);

  localparam int BW = 32 + 4*CB + IW;

  typedef struct packed {
    logic [gin_pkg::ID_W-1:0]    id;
    logic [gin_pkg::SCORE_W-1:0] score;
    logic [CB-1:0]               x1;
    logic [CB-1:0]               y1;
    logic [CB-1:0]               x2;
    logic [CB-1:0]               y2;
    logic [IW-1:0]               idx;
  } box_t;

  logic [BW-1:0] box_q, box_d;
  logic          valid_q, valid_d;
  box_t          cur, nb;

  assign cur = box_t'(box_q);
  assign nb  = box_t'(new_box_i);

  // a cell moves when it is empty or ranks below the new box
  assign ins_o = !(valid_q && (cur.score >= nb.score));

  // next cell content
  always_comb begin
    box_d   = box_q;
    valid_d = valid_q;
    if (ctl_i.rank_clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.rank_ins && ins_o) begin
      if (prev_ins_i) begin
        box_d   = prev_box_i;
        valid_d = prev_valid_i;
      end else begin
        box_d   = new_box_i;
        valid_d = 1'b1;
      end
    end else if (ctl_i.rank_shift) begin
      box_d   = next_box_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign box_o   = box_q;
  assign valid_o = valid_q;

endmodule

/* src/gin_id_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gin_id_cell
// One cell of the output chain: insertion by id then arrival, shift toward
// the head during emission.
// ----------------------------------------------------------------------------
module gin_id_cell #(
  parameter int CB = gin_pkg::COORD_BITS_DEF,
  parameter int IW = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gin_pkg::gin_ctl_t               ctl_i,
  input  logic [32+4*CB+IW-1:0]           new_box_i,
  input  logic [32+4*CB+IW-1:0]           prev_box_i,
  input  logic                            prev_valid_i,
  input  logic                            prev_ins_i,
  input  logic [32+4*CB+IW-1:0]           next_box_i,
  input  logic                            next_valid_i,
  output logic [32+4*CB+IW-1:0]           box_o,
  output logic                            valid_o,
  output logic                            ins_o
);

  localparam int BW = 32 + 4*CB + IW;

  typedef struct packed {
    logic [gin_pkg::ID_W-1:0]    id;
    logic [gin_pkg::SCORE_W-1:0] score;
    logic [CB-1:0]               x1;
    logic [CB-1:0]               y1;
    logic [CB-1:0]               x2;
    logic [CB-1:0]               y2;
    logic [IW-1:0]               idx;
  } box_t;

  logic [BW-1:0] box_q, box_d;
  logic          valid_q, valid_d;
  box_t          cur, nb;

  assign cur = box_t'(box_q);
  assign nb  = box_t'(new_box_i);

  // arrival index breaks id ties, so keys never match
  assign ins_o = !(valid_q && ({cur.id, cur.idx} < {nb.id, nb.idx}));

  // next cell content
  always_comb begin
    box_d   = box_q;
    valid_d = valid_q;
    if (ctl_i.id_ins && ins_o) begin
      if (prev_ins_i) begin
        box_d   = prev_box_i;
        valid_d = prev_valid_i;
      end else begin
        box_d   = new_box_i;
        valid_d = 1'b1;
      end
    end else if (ctl_i.id_shift) begin
      box_d   = next_box_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign box_o   = box_q;
  assign valid_o = valid_q;

endmodule

/* src/gin_iou_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gin_iou_pipe
// Five-stage overlap test of a ring box against the current kept box; a box
// that reaches the threshold leaves the ring as an empty slot.
// ----------------------------------------------------------------------------
module gin_iou_pipe #(
  parameter int CB = gin_pkg::COORD_BITS_DEF,
  parameter int IW = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clear_i,
  input  logic [gin_pkg::THR_W-1:0]       thr_i,
  input  logic [32+4*CB+IW-1:0]           k_box_i,
  input  logic [32+4*CB+IW-1:0]           in_box_i,
  input  logic                            in_valid_i,
  output logic [32+4*CB+IW-1:0]           out_box_o,
  output logic                            out_valid_o
);

  localparam int BW = 32 + 4*CB + IW;
  localparam int AW = 2*CB;
  localparam int UW = 2*CB + 1;
  localparam int PW = gin_pkg::THR_W + UW;
  localparam int LW = AW + 16;

  typedef struct packed {
    logic [gin_pkg::ID_W-1:0]    id;
    logic [gin_pkg::SCORE_W-1:0] score;
    logic [CB-1:0]               x1;
    logic [CB-1:0]               y1;
    logic [CB-1:0]               x2;
    logic [CB-1:0]               y2;
    logic [IW-1:0]               idx;
  } box_t;

  box_t          a, b;
  logic [CB-1:0] lx, rx, ty, by;
  logic          reach;

  // stage registers
  logic [BW-1:0] s1_box_q, s2_box_q, s3_box_q, s4_box_q, s5_box_q;
  logic          s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic          s1_ovl_q, s2_ovl_q, s3_ovl_q, s4_ovl_q;
  logic [CB-1:0] s1_dx_q, s1_dy_q, s1_wa_q, s1_ha_q, s1_wb_q, s1_hb_q;
  logic [AW-1:0] s2_ov_q, s2_ara_q, s2_arb_q, s3_ov_q;
  logic [UW-1:0] s3_uni_q;
  logic [PW-1:0] s4_prod_q;
  logic [LW-1:0] s4_lhs_q;

  assign a = box_t'(k_box_i);
  assign b = box_t'(in_box_i);

  // intersection edges
  assign lx = (a.x1 > b.x1) ? a.x1 : b.x1;
  assign rx = (a.x2 < b.x2) ? a.x2 : b.x2;
  assign ty = (a.y1 > b.y1) ? a.y1 : b.y1;
  assign by = (a.y2 < b.y2) ? a.y2 : b.y2;

  // no overlap reaches only a zero threshold
  assign reach = s4_ovl_q ? ({{(PW-LW){1'b0}}, s4_lhs_q} >= s4_prod_q)
                          : (thr_i == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (clear_i) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q && !reach;
    end
  end

  // datapath, one step per stage
  always_ff @(posedge clk_i) begin
    s1_box_q  <= in_box_i;
    s1_ovl_q  <= (rx > lx) && (by > ty);
    s1_dx_q   <= rx - lx;
    s1_dy_q   <= by - ty;
    s1_wa_q   <= a.x2 - a.x1;
    s1_ha_q   <= a.y2 - a.y1;
    s1_wb_q   <= b.x2 - b.x1;
    s1_hb_q   <= b.y2 - b.y1;

    s2_box_q  <= s1_box_q;
    s2_ovl_q  <= s1_ovl_q;
    s2_ov_q   <= s1_dx_q * s1_dy_q;
    s2_ara_q  <= s1_wa_q * s1_ha_q;
    s2_arb_q  <= s1_wb_q * s1_hb_q;

    s3_box_q  <= s2_box_q;
    s3_ovl_q  <= s2_ovl_q;
    s3_ov_q   <= s2_ov_q;
    s3_uni_q  <= {1'b0, s2_ara_q} + {1'b0, s2_arb_q} - {1'b0, s2_ov_q};

    s4_box_q  <= s3_box_q;
    s4_ovl_q  <= s3_ovl_q;
    s4_lhs_q  <= {s3_ov_q, 16'h0000};
    s4_prod_q <= {{UW{1'b0}}, thr_i} * {{gin_pkg::THR_W{1'b0}}, s3_uni_q};

    s5_box_q  <= s4_box_q;
  end

  assign out_box_o   = s5_box_q;
  assign out_valid_o = s5_v_q;

endmodule

/* src/greedy_iou_nms.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_iou_nms
// Greedy non-maximum suppression of detection boxes by IoU, built from a
// score-ranked chain of cells closed into a ring through an overlap test.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | box_id, score, corners, last
//  out     | output    | out_valid_o/out_ready_i | kept box, last_kept, dropped
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Boxes load at one per cycle; each is inserted by score into the chain while
//  it has room. After the last box the chain rotates through the overlap test:
//  each kept box costs one revolution of the ring, the gaps of suppressed
//  slots between kept boxes add under one revolution in all, and a final
//  empty revolution ends the search; reaching max_detections ends the search
//  in the cycle after that kept box is taken.
//  Results then leave at one per cycle, held while out_ready_i is low.
//  Input is taken only in the load phase; reset empties both chains at once.
// ----------------------------------------------------------------------------
module greedy_iou_nms #(
  parameter int MAX_BOXES  = gin_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = gin_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gin_pkg::ID_W-1:0]        box_id_i,
  input  logic [gin_pkg::SCORE_W-1:0]     score_i,
  input  logic [COORD_BITS-1:0]           left_x_i,
  input  logic [COORD_BITS-1:0]           top_y_i,
  input  logic [COORD_BITS-1:0]           right_x_i,
  input  logic [COORD_BITS-1:0]           bottom_y_i,
  input  logic                            last_box_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gin_pkg::ID_W-1:0]        kept_id_o,
  output logic [gin_pkg::SCORE_W-1:0]     kept_score_o,
  output logic [COORD_BITS-1:0]           kept_left_o,
  output logic [COORD_BITS-1:0]           kept_top_o,
  output logic [COORD_BITS-1:0]           kept_right_o,
  output logic [COORD_BITS-1:0]           kept_bottom_o,
  output logic                            last_kept_o,
  output logic                            dropped_overflow_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gin_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gin_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int CB   = COORD_BITS;
  localparam int IW   = $clog2(MAX_BOXES);
  localparam int CW   = $clog2(MAX_BOXES + 1);
  localparam int BW   = 32 + 4*CB + IW;
  localparam int RING = MAX_BOXES + gin_pkg::PIPE_DEPTH;
  localparam int RW   = $clog2(RING);
  localparam logic [RW-1:0] RING_LAST = RW'(RING - 1);

  typedef struct packed {
    logic [gin_pkg::ID_W-1:0]    id;
    logic [gin_pkg::SCORE_W-1:0] score;
    logic [CB-1:0]               x1;
    logic [CB-1:0]               y1;
    logic [CB-1:0]               x2;
    logic [CB-1:0]               y2;
    logic [IW-1:0]               idx;
  } box_t;

  gin_pkg::gin_state_e state_q, state_d;
  gin_pkg::gin_ctl_t   ctl;

  logic [CW-1:0]             count_q, count_d;
  logic                      ovf_q, ovf_d;
  logic                      set_ovf_q, set_ovf_d;
  logic [RW-1:0]             cnt_q, cnt_d;
  logic                      k_valid_q, k_valid_d;
  logic [BW-1:0]             k_box_q;
  logic [gin_pkg::DET_W-1:0] kept_q, kept_d, rem_q, rem_d;
  logic [gin_pkg::THR_W-1:0] thr_q, thr_d;
  logic [gin_pkg::DET_W-1:0] lim_q, lim_d;
  logic                      out_valid_q, out_valid_d;
  logic [BW-1:0]             out_box_q;
  logic                      out_last_q, out_ovf_q;
  logic                      in_fire, pop, load_out, pipe_in_valid;
  logic [BW-1:0]             new_box, pipe_box;
  logic                      pipe_valid;
  box_t                      ob;

  logic [BW-1:0]        rank_box  [MAX_BOXES];
  logic [MAX_BOXES-1:0] rank_valid, rank_ins;
  logic [BW-1:0]        id_box    [MAX_BOXES];
  logic [MAX_BOXES-1:0] id_valid, id_ins;

  assign in_fire = in_valid_i && in_ready_o;
  assign new_box = {box_id_i, score_i, left_x_i, top_y_i, right_x_i, bottom_y_i,
                    count_q[IW-1:0]};

  // score chain, head at cell 0, ring closes through the test unit
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_rank
    gin_rank_cell #(.CB(CB), .IW(IW)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_box_i    (new_box),
      .prev_box_i   ((i == 0) ? new_box : rank_box[(i == 0) ? 0 : i-1]),
      .prev_valid_i ((i == 0) ? 1'b0 : rank_valid[(i == 0) ? 0 : i-1]),
      .prev_ins_i   ((i == 0) ? 1'b0 : rank_ins[(i == 0) ? 0 : i-1]),
      .next_box_i   ((i == MAX_BOXES-1) ? pipe_box
                                        : rank_box[(i == MAX_BOXES-1) ? i : i+1]),
      .next_valid_i ((i == MAX_BOXES-1) ? pipe_valid
                                        : rank_valid[(i == MAX_BOXES-1) ? i : i+1]),
      .box_o        (rank_box[i]),
      .valid_o      (rank_valid[i]),
      .ins_o        (rank_ins[i])
    );
  end

  // overlap test against the current kept box
  gin_iou_pipe #(.CB(CB), .IW(IW)) u_iou (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (ctl.rank_clear),
    .thr_i       (thr_q),
    .k_box_i     (k_box_q),
    .in_box_i    (rank_box[0]),
    .in_valid_i  (pipe_in_valid),
    .out_box_o   (pipe_box),
    .out_valid_o (pipe_valid)
  );

  // output chain ordered by id, fed by each kept box
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_id
    gin_id_cell #(.CB(CB), .IW(IW)) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_box_i    (rank_box[0]),
      .prev_box_i   ((i == 0) ? rank_box[0] : id_box[(i == 0) ? 0 : i-1]),
      .prev_valid_i ((i == 0) ? 1'b0 : id_valid[(i == 0) ? 0 : i-1]),
      .prev_ins_i   ((i == 0) ? 1'b0 : id_ins[(i == 0) ? 0 : i-1]),
      .next_box_i   ((i == MAX_BOXES-1) ? id_box[i]
                                        : id_box[(i == MAX_BOXES-1) ? i : i+1]),
      .next_valid_i ((i == MAX_BOXES-1) ? 1'b0
                                        : id_valid[(i == MAX_BOXES-1) ? i : i+1]),
      .box_o        (id_box[i]),
      .valid_o      (id_valid[i]),
      .ins_o        (id_ins[i])
    );
  end

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    thr_d = thr_q;
    lim_d = lim_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        gin_pkg::CFG_IOU_THRESHOLD: thr_d = cfg_data_i[gin_pkg::THR_W-1:0];
        gin_pkg::CFG_MAX_DET:       lim_d = cfg_data_i[gin_pkg::DET_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: load, suppression ring, emission
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ovf_d         = ovf_q;
    set_ovf_d     = set_ovf_q;
    cnt_d         = cnt_q;
    k_valid_d     = k_valid_q;
    kept_d        = kept_q;
    rem_d         = rem_q;
    ctl           = '0;
    pop           = 1'b0;
    pipe_in_valid = 1'b0;
    load_out      = 1'b0;
    in_ready_o    = (state_q == gin_pkg::ST_LOAD);
    case (state_q)
      gin_pkg::ST_LOAD: begin
        if (in_fire) begin
          if (count_q < CW'(MAX_BOXES)) begin
            ctl.rank_ins = 1'b1;
            count_d      = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_box_i) begin
            count_d   = '0;
            ovf_d     = 1'b0;
            set_ovf_d = ovf_q || !(count_q < CW'(MAX_BOXES));
            cnt_d     = '0;
            k_valid_d = 1'b0;
            kept_d    = '0;
            state_d   = gin_pkg::ST_RING;
          end
        end
      end
      gin_pkg::ST_RING: begin
        if ((kept_q >= lim_q) ||
            (!k_valid_q && (cnt_q == RING_LAST) && !rank_valid[0])) begin
          ctl.rank_clear = 1'b1;
          rem_d          = kept_q;
          state_d        = gin_pkg::ST_EMIT;
        end else begin
          ctl.rank_shift = 1'b1;
          pop            = rank_valid[0] && !k_valid_q;
          pipe_in_valid  = rank_valid[0] && !pop;
          if (pop) begin
            ctl.id_ins = 1'b1;
            k_valid_d  = 1'b1;
            cnt_d      = RW'(1);
            kept_d     = kept_q + 1'b1;
          end else if (k_valid_q && (cnt_q == RING_LAST)) begin
            k_valid_d = 1'b0;
            cnt_d     = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      gin_pkg::ST_EMIT: begin
        if (rem_q == '0) begin
          state_d = gin_pkg::ST_LOAD;
        end else if (!out_valid_q || out_ready_i) begin
          load_out     = 1'b1;
          ctl.id_shift = 1'b1;
          rem_d        = rem_q - 1'b1;
        end
      end
      default: state_d = gin_pkg::ST_LOAD;
    endcase
  end

  // output register
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gin_pkg::ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      set_ovf_q   <= 1'b0;
      cnt_q       <= '0;
      k_valid_q   <= 1'b0;
      kept_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= gin_pkg::THR_RESET;
      lim_q       <= gin_pkg::DET_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      set_ovf_q   <= set_ovf_d;
      cnt_q       <= cnt_d;
      k_valid_q   <= k_valid_d;
      kept_q      <= kept_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
      lim_q       <= lim_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      k_box_q <= rank_box[0];
    end
    if (load_out) begin
      out_box_q  <= id_box[0];
      out_last_q <= (rem_q == gin_pkg::DET_W'(1));
      out_ovf_q  <= set_ovf_q;
    end
  end

  assign ob                 = box_t'(out_box_q);
  assign out_valid_o        = out_valid_q;
  assign kept_id_o          = ob.id;
  assign kept_score_o       = ob.score;
  assign kept_left_o        = ob.x1;
  assign kept_top_o         = ob.y1;
  assign kept_right_o       = ob.x2;
  assign kept_bottom_o      = ob.y2;
  assign last_kept_o        = out_last_q;
  assign dropped_overflow_o = out_ovf_q;

endmodule

/* src/gin_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gin_checker
// Port-level checks of the greedy IoU NMS block, bound to the top level.
// ----------------------------------------------------------------------------
module gin_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     last_box_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [gin_pkg::ID_W-1:0] kept_id_o,
  input logic                     last_kept_o,
  input logic                     cfg_ready_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kept_id_o))
    else $error("stalled result changed");

  // the set closes input until suppression is done
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_box_i |=> !in_ready_o)
    else $error("input open right after last box");

  // input stays closed while a set is still being emitted
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_kept_o |=> !in_ready_o)
    else $error("input open in the middle of emission");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port stalled");

endmodule

bind greedy_iou_nms gin_checker u_gin_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_box_i  (last_box_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kept_id_o   (kept_id_o),
  .last_kept_o (last_kept_o),
  .cfg_ready_o (cfg_ready_o)
);

/* test/nms_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_checker
// Watches the box, result and register channels of the NMS block, predicts
// the surviving boxes of every set and compares them field by field.
// ----------------------------------------------------------------------------
module nms_checker
  import gin_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [ID_W-1:0]      box_id_i,
  input  logic [SCORE_W-1:0]   score_i,
  input  logic [11:0]          left_x_i,
  input  logic [11:0]          top_y_i,
  input  logic [11:0]          right_x_i,
  input  logic [11:0]          bottom_y_i,
  input  logic                 last_box_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [ID_W-1:0]      kept_id_i,
  input  logic [SCORE_W-1:0]   kept_score_i,
  input  logic [11:0]          kept_left_i,
  input  logic [11:0]          kept_top_i,
  input  logic [11:0]          kept_right_i,
  input  logic [11:0]          kept_bottom_i,
  input  logic                 last_kept_i,
  input  logic                 dropped_overflow_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
    logic [11:0]        lx, ty, rx, by;
  } box_t;

  typedef struct packed {
    box_t b;
    logic last;
    logic ovf;
  } kept_t;

  box_t            stored_boxes[MAX_BOXES_DEF];
  int              stored_cnt;
  logic            ovf_seen;
  logic [THR_W-1:0] thr;
  logic [DET_W-1:0] max_det;
  kept_t           kept_q[$];

  assign pending_o = kept_q.size();

  // true when the overlap of a and b reaches the threshold
  function automatic bit overlap_hits(box_t a, box_t b, logic [THR_W-1:0] t);
    longint lx, rx, ty, by, ov, ua;
    lx = (a.lx > b.lx) ? a.lx : b.lx;
    rx = (a.rx < b.rx) ? a.rx : b.rx;
    ty = (a.ty > b.ty) ? a.ty : b.ty;
    by = (a.by < b.by) ? a.by : b.by;
    if (rx <= lx || by <= ty) return t == 0;
    ov = (rx - lx) * (by - ty);
    ua = longint'(a.rx - a.lx) * (a.by - a.ty) + longint'(b.rx - b.lx) * (b.by - b.ty) - ov;
    return ov * 65536 >= longint'(t) * ua;
  endfunction

  // rank, suppress, select and reorder the finished set
  task automatic close_set();
    int rank[$];
    bit keep[MAX_BOXES_DEF];
    int sel[$];
    int j, v;
    for (int i = 0; i < stored_cnt; i++) begin
      j = rank.size();
      while (j > 0 && stored_boxes[rank[j-1]].score < stored_boxes[i].score) j--;
      rank.insert(j, i);
    end
    for (int i = 0; i < stored_cnt; i++) begin
      keep[rank[i]] = 1'b1;
      for (int k = 0; k < i; k++) begin
        if (keep[rank[k]] && overlap_hits(stored_boxes[rank[i]], stored_boxes[rank[k]], thr)) begin
          keep[rank[i]] = 1'b0;
          break;
        end
      end
    end
    for (int i = 0; i < stored_cnt && sel.size() < max_det; i++)
      if (keep[rank[i]]) sel.push_back(rank[i]);
    for (int i = 1; i < sel.size(); i++) begin
      v = sel[i];
      j = i;
      while (j > 0 && (stored_boxes[sel[j-1]].id > stored_boxes[v].id ||
             (stored_boxes[sel[j-1]].id == stored_boxes[v].id && sel[j-1] > v))) begin
        sel[j] = sel[j-1];
        j--;
      end
      sel[j] = v;
    end
    for (int i = 0; i < sel.size(); i++)
      kept_q.push_back('{b: stored_boxes[sel[i]], last: (i == sel.size() - 1), ovf: ovf_seen});
    stored_cnt = 0;
    ovf_seen = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kept_t exp_k;
    box_t  got;
    if (!rst_ni) begin
      stored_cnt   = 0;
      ovf_seen     = 1'b0;
      thr          = THR_RESET;
      max_det      = DET_RESET;
      fail_count_o = 0;
      kept_q.delete();
    end else begin
      // register write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_IOU_THRESHOLD) thr = cfg_data_i[THR_W-1:0];
        else if (cfg_index_i == CFG_MAX_DET) max_det = cfg_data_i[DET_W-1:0];
      end
      // result transaction
      if (out_valid_i && out_ready_i) begin
        got = '{kept_id_i, kept_score_i, kept_left_i, kept_top_i, kept_right_i, kept_bottom_i};
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected result id %0d", $time, kept_id_i);
          fail_count_o++;
        end else begin
          exp_k = kept_q.pop_front();
          if (got !== exp_k.b || last_kept_i !== exp_k.last ||
              dropped_overflow_i !== exp_k.ovf) begin
            $display("%0t: expected %h last %b ovf %b, actual %h last %b ovf %b", $time,
                     exp_k.b, exp_k.last, exp_k.ovf, got, last_kept_i, dropped_overflow_i);
            fail_count_o++;
          end
        end
      end
      // box transaction
      if (in_valid_i && in_ready_i) begin
        if (stored_cnt < MAX_BOXES_DEF) begin
          stored_boxes[stored_cnt] = '{box_id_i, score_i, left_x_i, top_y_i, right_x_i, bottom_y_i};
          stored_cnt++;
        end else ovf_seen = 1'b1;
        if (last_box_i) close_set();
      end
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives sets of detection boxes and register writes into the NMS block
// under random idling and a long output stall; the checker judges results.
// ----------------------------------------------------------------------------
module tb;
  import gin_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic [ID_W-1:0] box_id_i = '0;
  logic [SCORE_W-1:0] score_i = '0;
  logic [11:0] left_x_i = '0, top_y_i = '0, right_x_i = '0, bottom_y_i = '0;
  logic last_box_i = 1'b0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic [ID_W-1:0] kept_id_o;
  logic [SCORE_W-1:0] kept_score_o;
  logic [11:0] kept_left_o, kept_top_o, kept_right_o, kept_bottom_o;
  logic last_kept_o, dropped_overflow_o;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_IOU_THRESHOLD;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  int fail_count, pending;
  int send_idle_pct = 31, recv_idle_pct = 52;
  bit long_hold = 1'b0;
  bit start_hold = 1'b0;
  int boxes_sent = 0;

  always #5 clk_i = ~clk_i;

  greedy_iou_nms dut (.*);

  nms_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .box_id_i, .score_i,
    .left_x_i, .top_y_i, .right_x_i, .bottom_y_i, .last_box_i,
    .out_valid_i(out_valid_o), .out_ready_i, .kept_id_i(kept_id_o),
    .kept_score_i(kept_score_o), .kept_left_i(kept_left_o), .kept_top_i(kept_top_o),
    .kept_right_i(kept_right_o), .kept_bottom_i(kept_bottom_o),
    .last_kept_i(last_kept_o), .dropped_overflow_i(dropped_overflow_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, or a long counted hold-off
  always @(posedge clk_i) begin
    if (long_hold) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off, counted in cycles
  initial begin
    wait (start_hold);
    long_hold = 1'b1;
    repeat (3000) @(posedge clk_i);
    long_hold = 1'b0;
  end

  task automatic send_box(logic [15:0] id, logic [15:0] sc, logic [11:0] lx,
                          logic [11:0] ty, logic [11:0] rx, logic [11:0] by, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    box_id_i <= id; score_i <= sc;
    left_x_i <= lx; top_y_i <= ty; right_x_i <= rx; bottom_y_i <= by;
    last_box_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    boxes_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for all results, then the search time of a full set
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (70 * 69 + 100) @(posedge clk_i);
  endtask

  // random set: clustered boxes so suppression happens, a few broken ones
  task automatic random_set(int n);
    logic [11:0] cx, cy, lx, ty, w, h;
    cx = 12'($urandom_range(3000));
    cy = 12'($urandom_range(3000));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        lx = 12'($urandom); ty = 12'($urandom); w = 12'($urandom); h = 12'($urandom);
        send_box(16'($urandom), 16'($urandom), lx, ty, w, h, i == n - 1);
      end else begin
        lx = cx + 12'($urandom_range(60)); ty = cy + 12'($urandom_range(60));
        w = 12'($urandom_range(1, 900)); h = 12'($urandom_range(1, 900));
        send_box(16'($urandom_range(40)),
                 ($urandom_range(3) == 0) ? 16'd500 : 16'($urandom),
                 lx, ty, lx + w, ty + h, i == n - 1);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, ties, inverted box, disjoint boxes
    send_box(16'hFFFF, 16'hFFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 1'b0);
    send_box(16'd0, 16'hFFFF, 12'd0, 12'd0, 12'hFFE, 12'hFFF, 1'b0);
    send_box(16'd7, 16'd0, 12'hFFF, 12'hFFF, 12'd0, 12'd0, 1'b0);
    send_box(16'd7, 16'd100, 12'd10, 12'd10, 12'd20, 12'd20, 1'b0);
    send_box(16'd3, 16'd100, 12'd30, 12'd30, 12'd30, 12'd40, 1'b1);
    send_box(16'h5555, 16'hAAAA, 12'h555, 12'hAAA, 12'hAAA, 12'hAAA, 1'b1);
    drain();
    write_reg(CFG_IOU_THRESHOLD, '0);
    write_reg(CFG_MAX_DET, 17'd1);
    send_box(16'd2, 16'd9, 12'd0, 12'd0, 12'd5, 12'd5, 1'b0);
    send_box(16'd1, 16'd8, 12'd100, 12'd100, 12'd105, 12'd105, 1'b1);
    drain();
    write_reg(CFG_IOU_THRESHOLD, 17'd65536);
    write_reg(CFG_MAX_DET, 17'd64);
    send_box(16'd4, 16'd9, 12'd0, 12'd0, 12'd50, 12'd50, 1'b0);
    send_box(16'd5, 16'd9, 12'd0, 12'd0, 12'd50, 12'd50, 1'b1);
    drain();
    write_reg(CFG_IOU_THRESHOLD, 17'h1FFFF);
    write_reg(CFG_MAX_DET, 17'd0);
    send_box(16'd6, 16'd1, 12'd0, 12'd0, 12'd50, 12'd50, 1'b1);
    drain();
    write_reg(CFG_MAX_DET, 17'd127);
    write_reg(CFG_IOU_THRESHOLD, 17'd32768);
    // overflow set, more boxes than the block holds
    random_set(66);
    drain();
    // random phases over several settings
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 52; recv_idle_pct = 31; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(CFG_IOU_THRESHOLD, 17'($urandom_range(65536)));
      write_reg(CFG_MAX_DET, 17'($urandom_range(1, 64)));
      for (int s = 0; s < 6; s++) begin
        random_set($urandom_range(1, 24));
        if (s == 2) begin
          // sender keeps offering; in the first phase the receiver holds off meanwhile
          if (ph == 0) start_hold = 1'b1;
          random_set(8);
        end
      end
      drain();
    end
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
